// ===== sv/gabb_pkg.sv =====
`default_nettype none

package gabb_pkg;

    localparam int PIX_W       = 16;
    localparam int ADDR_W      = 16;
    localparam int COV_W       = 8;
    localparam int CHAN_W      = 8;
    localparam int COLOR_W     = 24;
    localparam int CMD_W       = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int FRAME_CFG_W = 9;
    localparam int GLYPH_CFG_W = 7;
    localparam int ORIGIN_W    = 10;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_BLEND = 2'd2
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_GLYPH_COLS   = 3'd2,
        CFG_GLYPH_ROWS   = 3'd3,
        CFG_ORIGIN_COL   = 3'd4,
        CFG_ORIGIN_ROW   = 3'd5,
        CFG_TEXT_COLOR   = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_BLEND = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [PIX_W-1:0]  value;
        logic [ADDR_W-1:0] waddr;
        logic              done;
    } item_t;

    function automatic logic [2*CHAN_W-1:0] blend_sum(
        input logic [CHAN_W-1:0] fg,
        input logic [CHAN_W-1:0] bg,
        input logic [CHAN_W-1:0] alpha
    );
        logic [CHAN_W-1:0] inv;
        inv = 8'hFF - alpha;
        return ({8'b0, fg} * {8'b0, alpha}) + ({8'b0, bg} * {8'b0, inv});
    endfunction

    // exact x/255 for x up to 255*255
    function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] x);
        logic [2*CHAN_W:0] t;
        t = {1'b0, x} + 17'd1 + {9'b0, x[15:8]};
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

// ===== sv/gabb_queue.sv =====
`default_nettype none

module gabb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full      = count_reg == CW'(DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_data  = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |-> !full)
        else $error("queue pushed while full");

endmodule

`default_nettype wire

// ===== sv/gabb_front.sv =====
`default_nettype none

module gabb_front
    import gabb_pkg::*;
#(
    parameter int MAX_FRAME_WIDTH  = 256,
    parameter int MAX_FRAME_HEIGHT = 256,
    parameter int MAX_GLYPH_SIDE   = 64,
    parameter int STORE_AW         = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [CMD_W-1:0]       s_command,
    input  logic [ADDR_W-1:0]      s_pixel_address,
    input  logic [PIX_W-1:0]       s_pixel_value,
    input  logic [COV_W-1:0]       s_coverage,
    input  logic                   store_ready,
    input  logic                   q_full,
    output logic                   q_push,
    output item_t                  q_item,
    output logic [STORE_AW-1:0]    q_mem_addr,
    output logic [COLOR_W-1:0]     text_color
);

    localparam int STORE_SIZE = MAX_FRAME_WIDTH * MAX_FRAME_HEIGHT;
    localparam int FWW        = $clog2(MAX_FRAME_WIDTH + 1);
    localparam int FHW        = $clog2(MAX_FRAME_HEIGHT + 1);
    localparam int GW         = $clog2(MAX_GLYPH_SIDE + 1);
    localparam int COL_W      = $clog2(MAX_FRAME_WIDTH);
    localparam int ROW_W      = $clog2(MAX_FRAME_HEIGHT);
    localparam int IDX_W      = ROW_W + FWW;
    localparam int M1_W       = (GW > FWW) ? GW : FWW;
    localparam int M2_W       = (M1_W > FHW) ? M1_W : FHW;
    localparam int M3_W       = (M2_W > ORIGIN_W) ? M2_W : ORIGIN_W;
    localparam int PXW        = M3_W + 2;
    localparam int FW_RESET   = (256 > MAX_FRAME_WIDTH) ? MAX_FRAME_WIDTH : 256;
    localparam int FH_RESET   = (256 > MAX_FRAME_HEIGHT) ? MAX_FRAME_HEIGHT : 256;

    logic [FWW-1:0]             frame_w_reg;
    logic [FHW-1:0]             frame_h_reg;
    logic [GW-1:0]              glyph_cols_reg;
    logic [GW-1:0]              glyph_rows_reg;
    logic signed [ORIGIN_W-1:0] origin_col_reg;
    logic signed [ORIGIN_W-1:0] origin_row_reg;
    logic [COLOR_W-1:0]         text_color_reg;

    logic [FWW-1:0]             sat_w;
    logic [FHW-1:0]             sat_h;
    logic [GW-1:0]              sat_cols;
    logic [GW-1:0]              sat_rows;

    logic [GW-1:0]              col_pos_reg, row_pos_reg;
    logic [GW-1:0]              col_pos_next, row_pos_next;
    logic [GW-1:0]              cur_col, cur_row;
    logic [GW:0]                col_inc, row_inc;
    logic                       glyph_active, stale, wrap_done;
    logic                       accept, blend_take;
    logic signed [PXW-1:0]      px_next, py_next;

    logic                       f1_valid_reg;
    cmd_t                       f1_cmd_reg;
    logic [ADDR_W-1:0]          f1_addr_reg;
    logic [PIX_W-1:0]           f1_value_reg;
    logic [COV_W-1:0]           f1_cov_reg;
    logic signed [PXW-1:0]      f1_px_reg, f1_py_reg;
    logic                       f1_blend_reg;
    logic                       f1_done_reg;

    logic signed [PXW-1:0]      fw_s, fh_s;
    logic                       hit, addr_ok;
    logic [COL_W-1:0]           px_u;
    logic [ROW_W-1:0]           py_u;
    logic [IDX_W-1:0]           idx_wide;

    assign text_color = text_color_reg;

    // configuration; frame and glyph sizes saturated on the way in
    always_comb begin
        sat_w = (32'(cfg_data[FRAME_CFG_W-1:0]) > MAX_FRAME_WIDTH)
              ? FWW'(MAX_FRAME_WIDTH) : FWW'(cfg_data[FRAME_CFG_W-1:0]);
        sat_h = (32'(cfg_data[FRAME_CFG_W-1:0]) > MAX_FRAME_HEIGHT)
              ? FHW'(MAX_FRAME_HEIGHT) : FHW'(cfg_data[FRAME_CFG_W-1:0]);
        sat_cols = (32'(cfg_data[GLYPH_CFG_W-1:0]) > MAX_GLYPH_SIDE)
                 ? GW'(MAX_GLYPH_SIDE) : GW'(cfg_data[GLYPH_CFG_W-1:0]);
        sat_rows = sat_cols;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_w_reg    <= FWW'(FW_RESET);
            frame_h_reg    <= FHW'(FH_RESET);
            glyph_cols_reg <= '0;
            glyph_rows_reg <= '0;
            origin_col_reg <= '0;
            origin_row_reg <= '0;
            text_color_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_w_reg    <= sat_w;
                CFG_FRAME_HEIGHT: frame_h_reg    <= sat_h;
                CFG_GLYPH_COLS:   glyph_cols_reg <= sat_cols;
                CFG_GLYPH_ROWS:   glyph_rows_reg <= sat_rows;
                CFG_ORIGIN_COL:   origin_col_reg <= cfg_data[ORIGIN_W-1:0];
                CFG_ORIGIN_ROW:   origin_row_reg <= cfg_data[ORIGIN_W-1:0];
                CFG_TEXT_COLOR:   text_color_reg <= cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // glyph position tracking
    always_comb begin
        glyph_active = (glyph_cols_reg != '0) && (glyph_rows_reg != '0);
        stale        = (col_pos_reg >= glyph_cols_reg) || (row_pos_reg >= glyph_rows_reg);
        cur_col      = stale ? '0 : col_pos_reg;
        cur_row      = stale ? '0 : row_pos_reg;
        col_inc      = {1'b0, cur_col} + 1'b1;
        row_inc      = {1'b0, cur_row} + 1'b1;
        col_pos_next = col_inc[GW-1:0];
        row_pos_next = cur_row;
        wrap_done    = 1'b0;
        if (col_inc >= {1'b0, glyph_cols_reg}) begin
            col_pos_next = '0;
            row_pos_next = row_inc[GW-1:0];
            if (row_inc >= {1'b0, glyph_rows_reg}) begin
                row_pos_next = '0;
                wrap_done    = 1'b1;
            end
        end
        px_next = PXW'(origin_col_reg) + $signed(PXW'(cur_col));
        py_next = PXW'(origin_row_reg) + $signed(PXW'(cur_row));
    end

    assign q_push     = f1_valid_reg && !q_full;
    assign s_ready    = store_ready && (!f1_valid_reg || !q_full);
    assign accept     = s_valid && s_ready;
    assign blend_take = accept && (s_command == CMD_BLEND) && glyph_active;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            f1_valid_reg <= 1'b0;
        end else begin
            if (blend_take) begin
                col_pos_reg <= col_pos_next;
                row_pos_reg <= row_pos_next;
            end
            if (accept) begin
                f1_valid_reg <= 1'b1;
            end else if (q_push) begin
                f1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f1_cmd_reg   <= cmd_t'(s_command);
            f1_addr_reg  <= s_pixel_address;
            f1_value_reg <= s_pixel_value;
            f1_cov_reg   <= s_coverage;
            f1_px_reg    <= px_next;
            f1_py_reg    <= py_next;
            f1_blend_reg <= (s_command == CMD_BLEND) && glyph_active;
            f1_done_reg  <= (s_command == CMD_BLEND) && glyph_active && wrap_done;
        end
    end

    // clip, index and classify
    always_comb begin
        fw_s     = $signed(PXW'(frame_w_reg));
        fh_s     = $signed(PXW'(frame_h_reg));
        hit      = (f1_cov_reg != '0) && (f1_px_reg >= 0) && (f1_py_reg >= 0)
                && (f1_px_reg < fw_s) && (f1_py_reg < fh_s);
        px_u     = COL_W'(f1_px_reg);
        py_u     = ROW_W'(f1_py_reg);
        idx_wide = IDX_W'(py_u) * IDX_W'(frame_w_reg) + IDX_W'(px_u);
        addr_ok  = 32'(f1_addr_reg) < STORE_SIZE;

        q_item     = '{op: OP_NONE, value: f1_value_reg, waddr: '0, done: 1'b0};
        q_mem_addr = STORE_AW'(f1_addr_reg);
        unique case (f1_cmd_reg)
            CMD_WRITE: begin
                if (addr_ok) begin
                    q_item.op = OP_WRITE;
                end
            end
            CMD_READ: begin
                if (addr_ok) begin
                    q_item.op = OP_READ;
                end
            end
            CMD_BLEND: begin
                q_item.value = PIX_W'(f1_cov_reg);
                q_item.done  = f1_done_reg;
                q_mem_addr   = STORE_AW'(idx_wide);
                if (f1_blend_reg && hit) begin
                    q_item.op    = OP_BLEND;
                    q_item.waddr = ADDR_W'(idx_wide);
                end
            end
            default: ;
        endcase
    end

    a_hold_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        f1_valid_reg && q_full |=> f1_valid_reg)
        else $error("front stage dropped an item while queue full");

    a_done_only_blend: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push && q_item.done |-> f1_cmd_reg == CMD_BLEND)
        else $error("glyph end flagged on a non-blend item");

    a_ready_after_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !store_ready |-> !s_ready)
        else $error("input taken during store clear");

endmodule

`default_nettype wire

// ===== sv/gabb_back.sv =====
`default_nettype none

module gabb_back
    import gabb_pkg::*;
#(
    parameter int MAX_FRAME_WIDTH  = 256,
    parameter int MAX_FRAME_HEIGHT = 256,
    parameter int STORE_AW         = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [COLOR_W-1:0]  text_color,
    input  logic                q_valid,
    input  item_t               q_item,
    input  logic [STORE_AW-1:0] q_mem_addr,
    output logic                q_pop,
    output logic                store_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [PIX_W-1:0]    m_read_data,
    output logic                m_pixel_written,
    output logic [ADDR_W-1:0]   m_written_address,
    output logic                m_glyph_done
);

    localparam int STORE_SIZE = MAX_FRAME_WIDTH * MAX_FRAME_HEIGHT;

    logic [PIX_W-1:0]    mem [STORE_SIZE];
    logic [PIX_W-1:0]    rd_data_reg;

    logic                clr_active_reg;
    logic [STORE_AW-1:0] clr_addr_reg;

    logic                adv, mem_we;

    logic                s1_valid_reg;
    item_t               s1_item_reg;
    logic [STORE_AW-1:0] s1_addr_reg;

    logic                s2_valid_reg;
    item_t               s2_item_reg;
    logic [STORE_AW-1:0] s2_addr_reg;
    logic [2*CHAN_W-1:0] s2_sum_r_reg, s2_sum_g_reg, s2_sum_b_reg;
    logic [PIX_W-1:0]    s2_rdpix_reg;

    logic                lw_valid_reg;
    logic [STORE_AW-1:0] lw_addr_reg;
    logic [PIX_W-1:0]    lw_data_reg;

    logic                m_valid_reg;
    logic [PIX_W-1:0]    m_read_data_reg;
    logic                m_pixel_written_reg;
    logic [ADDR_W-1:0]   m_written_address_reg;
    logic                m_glyph_done_reg;

    logic [PIX_W-1:0]    bg_pix, s2_pixel;
    logic [CHAN_W-1:0]   bg_r, bg_g, bg_b, alpha;
    logic [2*CHAN_W-1:0] sum_r, sum_g, sum_b;
    logic [CHAN_W-1:0]   res_r, res_g, res_b;
    logic                s2_writes;

    assign adv         = !m_valid_reg || m_ready;
    assign q_pop       = adv && q_valid && !clr_active_reg;
    assign store_ready = !clr_active_reg;
    assign s2_writes   = (s2_item_reg.op == OP_WRITE) || (s2_item_reg.op == OP_BLEND);
    assign mem_we      = adv && s2_valid_reg && s2_writes;

    // frame store: clear sweep or pipeline write, registered read
    always_ff @(posedge aclk) begin
        if (clr_active_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (mem_we) begin
            mem[s2_addr_reg] <= s2_pixel;
        end
        if (adv) begin
            rd_data_reg <= mem[q_mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == STORE_AW'(STORE_SIZE - 1)) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // background with forwarding from the write stage and the last write
    always_comb begin
        if (s2_valid_reg && s2_writes && (s2_addr_reg == s1_addr_reg)) begin
            bg_pix = s2_pixel;
        end else if (lw_valid_reg && (lw_addr_reg == s1_addr_reg)) begin
            bg_pix = lw_data_reg;
        end else begin
            bg_pix = rd_data_reg;
        end
        bg_r  = {bg_pix[15:11], 3'b000};
        bg_g  = {bg_pix[10:5], 2'b00};
        bg_b  = {bg_pix[4:0], 3'b000};
        alpha = s1_item_reg.value[COV_W-1:0];
        sum_r = blend_sum(text_color[23:16], bg_r, alpha);
        sum_g = blend_sum(text_color[15:8], bg_g, alpha);
        sum_b = blend_sum(text_color[7:0], bg_b, alpha);
    end

    always_comb begin
        res_r    = div255(s2_sum_r_reg);
        res_g    = div255(s2_sum_g_reg);
        res_b    = div255(s2_sum_b_reg);
        s2_pixel = (s2_item_reg.op == OP_WRITE) ? s2_item_reg.value
                 : {res_r[7:3], res_g[7:2], res_b[7:3]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            lw_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                s1_valid_reg <= q_pop;
                s2_valid_reg <= s1_valid_reg;
                m_valid_reg  <= s2_valid_reg;
            end
            if (mem_we) begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_item_reg  <= q_item;
            s1_addr_reg  <= q_mem_addr;
            s2_item_reg  <= s1_item_reg;
            s2_addr_reg  <= s1_addr_reg;
            s2_sum_r_reg <= sum_r;
            s2_sum_g_reg <= sum_g;
            s2_sum_b_reg <= sum_b;
            s2_rdpix_reg <= bg_pix;
            m_read_data_reg       <= (s2_item_reg.op == OP_READ) ? s2_rdpix_reg : '0;
            m_pixel_written_reg   <= s2_item_reg.op == OP_BLEND;
            m_written_address_reg <= (s2_item_reg.op == OP_BLEND) ? s2_item_reg.waddr : '0;
            m_glyph_done_reg      <= s2_item_reg.done;
        end
        if (mem_we) begin
            lw_addr_reg <= s2_addr_reg;
            lw_data_reg <= s2_pixel;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_read_data       = m_read_data_reg;
    assign m_pixel_written   = m_pixel_written_reg;
    assign m_written_address = m_written_address_reg;
    assign m_glyph_done      = m_glyph_done_reg;

    a_clear_blocks_write: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !mem_we && !s1_valid_reg && !s2_valid_reg)
        else $error("pipeline active during store clear");

    a_last_write_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> lw_valid_reg && (lw_addr_reg == $past(s2_addr_reg)))
        else $error("last-write register out of step");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && s2_valid_reg |=> m_valid_reg)
        else $error("result lost at output register");

    a_written_only_blend: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && s2_valid_reg && (s2_item_reg.op != OP_BLEND) |=> !m_pixel_written)
        else $error("pixel write flagged on a non-blend item");

endmodule

`default_nettype wire

// ===== sv/glyph_alpha_blend_blitter.sv =====
// Glyph alpha-blend blitter over an RGB565 frame store.
// Configuration channel cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write registers only while the block is idle.
// Input channel s_valid/s_ready carries write, read or blend-coverage transactions;
// result channel m_valid/m_ready returns exactly one transaction per input.
// An accepted input passes the front register, the queue, the s1 and s2 stages and the output register.
// Throughput: one transaction per cycle while m_ready holds high, including back-to-back
// blends on the same pixel; the frame store takes one read and one write per cycle, and
// read-after-write hazards between neighboring transactions are resolved by forwarding.
// Reset: a clearing pass zeroes all MAX_FRAME_WIDTH*MAX_FRAME_HEIGHT pixels of the
// frame store (65536 by default), one pixel per cycle; s_ready stays low meanwhile,
// configuration writes are still taken. Glyph position returns to the
// top-left corner and registers take their reset values.
// When m_ready is low the back pipeline holds; the input side keeps accepting until
// its queue and front register fill, then drops s_ready.
`default_nettype none

module glyph_alpha_blend_blitter
    import gabb_pkg::*;
#(
    parameter int MAX_FRAME_WIDTH  = 256,
    parameter int MAX_FRAME_HEIGHT = 256,
    parameter int MAX_GLYPH_SIDE   = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [CMD_W-1:0]       s_command,
    input  logic [ADDR_W-1:0]      s_pixel_address,
    input  logic [PIX_W-1:0]       s_pixel_value,
    input  logic [COV_W-1:0]       s_coverage,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [PIX_W-1:0]       m_read_data,
    output logic                   m_pixel_written,
    output logic [ADDR_W-1:0]      m_written_address,
    output logic                   m_glyph_done
);

    localparam int STORE_AW    = $clog2(MAX_FRAME_WIDTH * MAX_FRAME_HEIGHT);
    localparam int ITEM_W      = $bits(item_t);
    localparam int QW          = ITEM_W + STORE_AW;
    localparam int QUEUE_DEPTH = 4;

    logic                store_ready;
    logic                q_full, q_push, q_pop, q_valid;
    item_t               push_item, pop_item;
    logic [STORE_AW-1:0] push_addr, pop_addr;
    logic [QW-1:0]       push_data, pop_data;
    logic [COLOR_W-1:0]  text_color;

    assign cfg_ready = 1'b1;
    assign push_data = {push_addr, push_item};
    assign pop_item  = item_t'(pop_data[ITEM_W-1:0]);
    assign pop_addr  = pop_data[QW-1:ITEM_W];

    gabb_front #(
        .MAX_FRAME_WIDTH  (MAX_FRAME_WIDTH),
        .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT),
        .MAX_GLYPH_SIDE   (MAX_GLYPH_SIDE),
        .STORE_AW         (STORE_AW)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_pixel_address (s_pixel_address),
        .s_pixel_value   (s_pixel_value),
        .s_coverage      (s_coverage),
        .store_ready     (store_ready),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_item          (push_item),
        .q_mem_addr      (push_addr),
        .text_color      (text_color)
    );

    gabb_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (pop_data)
    );

    gabb_back #(
        .MAX_FRAME_WIDTH  (MAX_FRAME_WIDTH),
        .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT),
        .STORE_AW         (STORE_AW)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .text_color        (text_color),
        .q_valid           (q_valid),
        .q_item            (pop_item),
        .q_mem_addr        (pop_addr),
        .q_pop             (q_pop),
        .store_ready       (store_ready),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_read_data       (m_read_data),
        .m_pixel_written   (m_pixel_written),
        .m_written_address (m_written_address),
        .m_glyph_done      (m_glyph_done)
    );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
module testbench
    import gabb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int FRAME_MAX    = 256;
    localparam int GLYPH_MAX    = 64;
    localparam int FRAME_CELLS  = FRAME_MAX * FRAME_MAX;
    localparam int FULL_ALPHA   = 255;
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_ITEMS  = 44;
    localparam int HOLD_PHASE   = 2;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 16;
    localparam int QUIET_LIMIT  = 4 * FRAME_CELLS + 8000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  value;
        logic [COV_W-1:0]  cov;
    } blit_item_t;

    typedef struct packed {
        logic [PIX_W-1:0]  read_data;
        logic              pixel_written;
        logic [ADDR_W-1:0] written_address;
        logic              glyph_done;
    } blit_result_t;

    typedef struct packed {
        logic                  is_reg;
        cfg_index_t            reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        blit_item_t            item;
        logic                  typed_ok;
        blit_result_t          typed;
    } script_row_t;

    localparam blit_result_t NO_RESULT = '0;

    logic                   aclk              = 1'b0;
    logic                   aresetn           = 1'b0;
    logic                   cfg_valid         = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index         = '0;
    logic [CFG_DATA_W-1:0]  cfg_data          = '0;
    logic                   s_valid           = 1'b0;
    logic                   s_ready;
    logic [CMD_W-1:0]       s_command         = '0;
    logic [ADDR_W-1:0]      s_pixel_address   = '0;
    logic [PIX_W-1:0]       s_pixel_value     = '0;
    logic [COV_W-1:0]       s_coverage        = '0;
    logic                   m_valid;
    logic                   m_ready           = 1'b0;
    logic [PIX_W-1:0]       m_read_data;
    logic                   m_pixel_written;
    logic [ADDR_W-1:0]      m_written_address;
    logic                   m_glyph_done;

    // predictor state
    logic [PIX_W-1:0]         frame_mem [FRAME_CELLS] = '{default: '0};
    int                       glyph_col = 0;
    int                       glyph_row = 0;
    logic [FRAME_CFG_W-1:0]   frame_w_reg    = 9'd256;
    logic [FRAME_CFG_W-1:0]   frame_h_reg    = 9'd256;
    logic [GLYPH_CFG_W-1:0]   glyph_cols_reg = '0;
    logic [GLYPH_CFG_W-1:0]   glyph_rows_reg = '0;
    logic signed [ORIGIN_W-1:0] origin_col_reg = '0;
    logic signed [ORIGIN_W-1:0] origin_row_reg = '0;
    logic [COLOR_W-1:0]       text_color_reg = '0;

    blit_result_t results_due [$];
    int           fail_count   = 0;
    int           quiet_cycles = 0;
    bit           tx_gaps_on   = 1'b1;
    bit           rx_stalls_on = 1'b1;
    bit           rx_hold_req  = 1'b0;

    glyph_alpha_blend_blitter i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_pixel_address   (s_pixel_address),
        .s_pixel_value     (s_pixel_value),
        .s_coverage        (s_coverage),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_read_data       (m_read_data),
        .m_pixel_written   (m_pixel_written),
        .m_written_address (m_written_address),
        .m_glyph_done      (m_glyph_done)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [CHAN_W-1:0] mix_channel(input int fg, input int bg, input int alpha);
        return CHAN_W'((fg * alpha + bg * (FULL_ALPHA - alpha)) / FULL_ALPHA);
    endfunction

    function automatic blit_result_t predict_blit(input blit_item_t it);
        blit_result_t      res;
        int                cols, rows, fw, fh, px, py, idx;
        logic [PIX_W-1:0]  bg;
        logic [CHAN_W-1:0] red, grn, blu;
        res = NO_RESULT;
        case (it.cmd)
            CMD_WRITE: frame_mem[it.addr] = it.value;
            CMD_READ:  res.read_data = frame_mem[it.addr];
            CMD_BLEND: begin
                cols = (int'(glyph_cols_reg) > GLYPH_MAX) ? GLYPH_MAX : int'(glyph_cols_reg);
                rows = (int'(glyph_rows_reg) > GLYPH_MAX) ? GLYPH_MAX : int'(glyph_rows_reg);
                fw   = (int'(frame_w_reg) > FRAME_MAX) ? FRAME_MAX : int'(frame_w_reg);
                fh   = (int'(frame_h_reg) > FRAME_MAX) ? FRAME_MAX : int'(frame_h_reg);
                if (cols != 0 && rows != 0) begin
                    if (glyph_col >= cols || glyph_row >= rows) begin
                        glyph_col = 0;
                        glyph_row = 0;
                    end
                    px = int'(origin_col_reg) + glyph_col;
                    py = int'(origin_row_reg) + glyph_row;
                    if (it.cov != 0 && px >= 0 && py >= 0 && px < fw && py < fh) begin
                        idx = py * fw + px;
                        bg  = frame_mem[idx];
                        red = mix_channel(int'(text_color_reg[23:16]),
                                          int'({bg[15:11], 3'b000}), int'(it.cov));
                        grn = mix_channel(int'(text_color_reg[15:8]),
                                          int'({bg[10:5], 2'b00}), int'(it.cov));
                        blu = mix_channel(int'(text_color_reg[7:0]),
                                          int'({bg[4:0], 3'b000}), int'(it.cov));
                        frame_mem[idx] = {red[7:3], grn[7:2], blu[7:3]};
                        res.pixel_written   = 1'b1;
                        res.written_address = ADDR_W'(idx);
                    end
                    glyph_col++;
                    if (glyph_col >= cols) begin
                        glyph_col = 0;
                        glyph_row++;
                        if (glyph_row >= rows) begin
                            glyph_row = 0;
                            res.glyph_done = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic script_row_t reg_row(input cfg_index_t idx,
                                            input logic [CFG_DATA_W-1:0] value);
        script_row_t row;
        row           = '0;
        row.is_reg    = 1'b1;
        row.reg_index = idx;
        row.reg_value = value;
        return row;
    endfunction

    function automatic script_row_t item_row(input logic [CMD_W-1:0] cmd,
                                             input logic [ADDR_W-1:0] addr,
                                             input logic [PIX_W-1:0] value,
                                             input logic [COV_W-1:0] cov);
        script_row_t row;
        row      = '0;
        row.item = '{cmd, addr, value, cov};
        return row;
    endfunction

    function automatic script_row_t checked_row(input logic [CMD_W-1:0] cmd,
                                                input logic [ADDR_W-1:0] addr,
                                                input logic [PIX_W-1:0] value,
                                                input logic [COV_W-1:0] cov,
                                                input blit_result_t want);
        script_row_t row;
        row          = item_row(cmd, addr, value, cov);
        row.typed_ok = 1'b1;
        row.typed    = want;
        return row;
    endfunction

    function automatic blit_item_t random_item();
        blit_item_t it;
        int         k;
        k        = $urandom_range(0, 99);
        it.addr  = ($urandom_range(0, 1) != 0) ? ADDR_W'($urandom)
                                                : ADDR_W'($urandom_range(0, 4095));
        it.value = PIX_W'($urandom);
        it.cov   = COV_W'($urandom);
        if (k < 70) begin
            it.cmd = CMD_BLEND;
            case ($urandom_range(0, 5))
                0: it.cov = '0;
                1: it.cov = '1;
                default: ;
            endcase
        end else if (k < 82) begin
            it.cmd = CMD_WRITE;
        end else if (k < 94) begin
            it.cmd = CMD_READ;
        end else begin
            it.cmd = CMD_UNUSED;
        end
        return it;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input cfg_index_t idx);
        logic [CFG_DATA_W-1:0] junk, mask, v;
        int                    k;
        junk = CFG_DATA_W'($urandom);
        k    = $urandom_range(0, 9);
        case (idx)
            CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT: begin
                mask = CFG_DATA_W'((1 << FRAME_CFG_W) - 1);
                case (k)
                    0:       v = '0;
                    1:       v = CFG_DATA_W'(1);
                    2, 3:    v = CFG_DATA_W'(FRAME_MAX);
                    4:       v = CFG_DATA_W'($urandom_range(FRAME_MAX + 1,
                                                            (1 << FRAME_CFG_W) - 1));
                    default: v = CFG_DATA_W'($urandom_range(2, FRAME_MAX - 1));
                endcase
            end
            CFG_GLYPH_COLS, CFG_GLYPH_ROWS: begin
                mask = CFG_DATA_W'((1 << GLYPH_CFG_W) - 1);
                case (k)
                    0:       v = '0;
                    1:       v = CFG_DATA_W'(GLYPH_MAX);
                    2:       v = CFG_DATA_W'($urandom_range(GLYPH_MAX + 1,
                                                            (1 << GLYPH_CFG_W) - 1));
                    default: v = CFG_DATA_W'($urandom_range(1, 8));
                endcase
            end
            CFG_ORIGIN_COL, CFG_ORIGIN_ROW: begin
                mask = CFG_DATA_W'((1 << ORIGIN_W) - 1);
                case (k)
                    0:       v = CFG_DATA_W'(10'h200);
                    1:       v = CFG_DATA_W'(10'h1FF);
                    default: v = CFG_DATA_W'(int'($urandom_range(0, 24)) - 4);
                endcase
            end
            default: begin
                mask = '1;
                v    = junk;
            end
        endcase
        return (junk & ~mask) | (v & mask);
    endfunction

    task automatic note_failure(input string what, input blit_result_t got,
                                input blit_result_t want);
        if (fail_count < REPORT_MAX)
            $display("%0t %s: read_data %h/%h written %b/%b address %h/%h done %b/%b",
                     $realtime, what, got.read_data, want.read_data,
                     got.pixel_written, want.pixel_written,
                     got.written_address, want.written_address,
                     got.glyph_done, want.glyph_done);
        fail_count++;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (idx)
            CFG_FRAME_WIDTH:  frame_w_reg    = value[FRAME_CFG_W-1:0];
            CFG_FRAME_HEIGHT: frame_h_reg    = value[FRAME_CFG_W-1:0];
            CFG_GLYPH_COLS:   glyph_cols_reg = value[GLYPH_CFG_W-1:0];
            CFG_GLYPH_ROWS:   glyph_rows_reg = value[GLYPH_CFG_W-1:0];
            CFG_ORIGIN_COL:   origin_col_reg = value[ORIGIN_W-1:0];
            CFG_ORIGIN_ROW:   origin_row_reg = value[ORIGIN_W-1:0];
            CFG_TEXT_COLOR:   text_color_reg = value[COLOR_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input blit_item_t it, input bit typed_ok,
                             input blit_result_t typed);
        int           gap;
        blit_result_t want;
        gap = tx_gaps_on ? $urandom_range(0, 7) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_command       <= it.cmd;
        s_pixel_address <= it.addr;
        s_pixel_value   <= it.value;
        s_coverage      <= it.cov;
        do @(posedge aclk); while (s_ready !== 1'b1);
        want = predict_blit(it);
        results_due.push_back(typed_ok ? typed : want);
    endtask

    always begin : result_sink
        int           stall;
        blit_result_t got;
        @(negedge aclk);
        stall = rx_stalls_on ? $urandom_range(0, 7) : 0;
        if (rx_hold_req) begin
            stall       = HOLD_CYCLES;
            rx_hold_req = 1'b0;
        end
        if (stall > 0) begin
            m_ready <= 1'b0;
            repeat (stall) @(negedge aclk);
        end
        m_ready <= 1'b1;
        do @(posedge aclk); while (m_valid !== 1'b1);
        got = '{m_read_data, m_pixel_written, m_written_address, m_glyph_done};
        if (results_due.size() == 0) begin
            note_failure("result with nothing due", got, NO_RESULT);
        end else begin
            if (got.read_data !== results_due[0].read_data
                || got.pixel_written !== results_due[0].pixel_written
                || got.written_address !== results_due[0].written_address
                || got.glyph_done !== results_due[0].glyph_done)
                note_failure("result mismatch", got, results_due[0]);
            void'(results_due.pop_front());
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        script_row_t script [$];
        script = '{
            checked_row(CMD_READ,   16'h0000, 16'h0000, 8'h00, NO_RESULT),
            checked_row(CMD_READ,   16'hFFFF, 16'h0000, 8'h00, NO_RESULT),
            checked_row(CMD_BLEND,  16'h0000, 16'h0000, 8'hFF, NO_RESULT),
            checked_row(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, NO_RESULT),
            checked_row(CMD_WRITE,  16'hFFFF, 16'hFFFF, 8'hFF, NO_RESULT),
            checked_row(CMD_READ,   16'hFFFF, 16'h0000, 8'h00, '{16'hFFFF, 1'b0, 16'h0, 1'b0}),
            reg_row(CFG_GLYPH_COLS, 24'd2),
            checked_row(CMD_BLEND,  16'h0000, 16'h0000, 8'hFF, NO_RESULT),
            reg_row(CFG_GLYPH_ROWS, 24'd2),
            reg_row(CFG_TEXT_COLOR, 24'hFFFFFF),
            checked_row(CMD_BLEND,  16'h0000, 16'h0000, 8'hFF, '{16'h0, 1'b1, 16'h0, 1'b0}),
            checked_row(CMD_BLEND,  16'h0000, 16'h0000, 8'h00, NO_RESULT),
            checked_row(CMD_BLEND,  16'h0000, 16'h0000, 8'hFF, '{16'h0, 1'b1, 16'h100, 1'b0}),
            item_row(CMD_BLEND,     16'h0000, 16'h0000, 8'h80),
            checked_row(CMD_READ,   16'h0100, 16'h0000, 8'h00, '{16'hFFFF, 1'b0, 16'h0, 1'b0}),
            reg_row(CFG_FRAME_WIDTH, 24'h0001FF),
            reg_row(CFG_FRAME_HEIGHT, 24'h000000),
            checked_row(CMD_BLEND,  16'h0000, 16'h0000, 8'hFF, NO_RESULT),
            checked_row(CMD_BLEND,  16'h0000, 16'h0000, 8'hFF, NO_RESULT),
            reg_row(CFG_FRAME_HEIGHT, 24'h0001FF),
            reg_row(CFG_ORIGIN_COL, 24'hFFFE00),
            reg_row(CFG_ORIGIN_ROW, 24'h0001FF),
            checked_row(CMD_BLEND,  16'h0000, 16'h0000, 8'hFF, NO_RESULT),
            checked_row(CMD_BLEND,  16'h0000, 16'h0000, 8'hFF, '{16'h0, 1'b0, 16'h0, 1'b1}),
            reg_row(CFG_ORIGIN_COL, 24'h0003FF),
            reg_row(CFG_ORIGIN_ROW, 24'h0000FF),
            reg_row(CFG_GLYPH_COLS, 24'h00007F),
            reg_row(CFG_GLYPH_ROWS, 24'd1),
            reg_row(CFG_TEXT_COLOR, 24'h000000),
            checked_row(CMD_BLEND,  16'h0000, 16'h0000, 8'hFF, NO_RESULT),
            checked_row(CMD_BLEND,  16'h0000, 16'h0000, 8'hFF, '{16'h0, 1'b1, 16'hFF00, 1'b0}),
            item_row(CMD_BLEND,     16'h0000, 16'h0000, 8'h01),
            reg_row(CFG_GLYPH_COLS, 24'd2),
            checked_row(CMD_BLEND,  16'h0000, 16'h0000, 8'hFF, NO_RESULT),
            checked_row(CMD_BLEND,  16'h0000, 16'h0000, 8'hFF, '{16'h0, 1'b1, 16'hFF00, 1'b1}),
            checked_row(CMD_WRITE,  16'h1234, 16'h5AA5, 8'h00, NO_RESULT),
            checked_row(CMD_READ,   16'h1234, 16'h0000, 8'h00, '{16'h5AA5, 1'b0, 16'h0, 1'b0})
        };

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            if (script[i].is_reg)
                write_reg(script[i].reg_index, script[i].reg_value);
            else
                send_item(script[i].item, script[i].typed_ok, script[i].typed);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            write_reg(CFG_FRAME_WIDTH, pick_reg_value(CFG_FRAME_WIDTH));
            write_reg(CFG_FRAME_HEIGHT, pick_reg_value(CFG_FRAME_HEIGHT));
            write_reg(CFG_GLYPH_COLS, pick_reg_value(CFG_GLYPH_COLS));
            write_reg(CFG_GLYPH_ROWS, pick_reg_value(CFG_GLYPH_ROWS));
            write_reg(CFG_ORIGIN_COL, pick_reg_value(CFG_ORIGIN_COL));
            write_reg(CFG_ORIGIN_ROW, pick_reg_value(CFG_ORIGIN_ROW));
            write_reg(CFG_TEXT_COLOR, pick_reg_value(CFG_TEXT_COLOR));
            tx_gaps_on   = ($urandom_range(0, 2) != 0);
            rx_stalls_on = ($urandom_range(0, 2) != 0);
            // hold the sink so the pipeline fills and back-pressures the source
            if (phase == HOLD_PHASE) begin
                tx_gaps_on  = 1'b0;
                rx_hold_req = 1'b1;
            end
            repeat (PHASE_ITEMS)
                send_item(random_item(), 1'b0, NO_RESULT);
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
